[hw/rtl/gtip_pkg.sv]
package gtip_pkg;

  // Input beat: one file byte and the start-of-file marker
  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] tensor_index;
    logic [7:0]  name_byte;
    logic [31:0] dim_count;
    logic [63:0] dim0;
    logic [63:0] dim1;
    logic [63:0] dim2;
    logic [63:0] dim3;
    logic [31:0] elem_type;
    logic [63:0] data_offset;
    logic [63:0] byte_size;
    logic [3:0]  error_code;
  } out_beat_t;

  // Result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_REC  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Error codes
  localparam logic [3:0] ERR_SHORT  = 4'd1;
  localparam logic [3:0] ERR_MAGIC  = 4'd2;
  localparam logic [3:0] ERR_COUNTS = 4'd3;
  localparam logic [3:0] ERR_KEY    = 4'd4;
  localparam logic [3:0] ERR_VALUE  = 4'd5;
  localparam logic [3:0] ERR_STRING = 4'd6;
  localparam logic [3:0] ERR_ARRAY  = 4'd7;
  localparam logic [3:0] ERR_NAME   = 4'd8;
  localparam logic [3:0] ERR_TRUNC  = 4'd9;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_FILE_SIZE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_KV      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TENSORS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_KEY     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STRING  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_NAME_LIMIT  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_CAP  = 3'd6;
  localparam int unsigned CfgDataW = 40;

  // Format constants and register reset values
  localparam logic [31:0] MAGIC_WORD    = 32'h4655_4747;
  localparam logic [39:0] HEADER_BYTES  = 40'd24;
  localparam logic [12:0] MAX_RECORDS   = 13'd4096;
  localparam logic [15:0] RST_MAX_KV    = 16'd1000;
  localparam logic [15:0] RST_MAX_TENS  = 16'd10000;
  localparam logic [15:0] RST_MAX_KEY   = 16'd1024;
  localparam logic [23:0] RST_MAX_STR   = 24'd100000;
  localparam logic [7:0]  RST_NAME_LIM  = 8'd128;
  localparam logic [12:0] RST_REC_CAP   = 13'd512;

  // Value type codes that change parsing
  localparam logic [31:0] VT_STRING = 32'd8;
  localparam logic [31:0] VT_ARRAY  = 32'd9;

  // Scalar size as a shift: 1, 2, 4 or 8 bytes
  function automatic logic [1:0] scalar_shift(input logic [31:0] t);
    logic [1:0] sh;
    unique case (t)
      32'd0, 32'd1, 32'd7: sh = 2'd0;
      32'd2, 32'd3:        sh = 2'd1;
      32'd4, 32'd5, 32'd6: sh = 2'd2;
      default:             sh = 2'd3;
    endcase
    return sh;
  endfunction

  // Tensor size from element count and type, by shifts and adds
  function automatic logic [63:0] tensor_bytes(input logic [63:0] n, input logic [31:0] t);
    logic [63:0] q32;
    logic [63:0] q256;
    logic [63:0] r;
    q32  = n >> 5;
    q256 = n >> 8;
    unique case (t)
      32'd1:   r = n << 1;
      32'd2:   r = (q32 << 4) + (q32 << 1);
      32'd8:   r = (q32 << 5) + (q32 << 1);
      32'd12:  r = (q256 << 7) + (q256 << 4);
      32'd13:  r = (q256 << 7) + (q256 << 5) + (q256 << 4);
      default: r = n << 2;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/gguf_tensor_info_parser_core.sv]
// Tensor table parser for GGUF model files, fed one file byte per beat.
// Input channel: in_valid_i / in_stall_o carry in_data_i (file byte and a
// first-byte marker that restarts parsing). Output channel: out_valid_o /
// out_stall_i carry out_data_o: name bytes, tensor records, a done beat
// with the 256-aligned data start, or an error beat.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high; write only while the block is idle.
// Throughput: one byte per cycle unless in_stall_o is high. Each byte is
// parsed in the cycle it is accepted; its zero, one or two result beats
// enter a four-entry queue, the first on out_valid_o next cycle if empty.
// in_stall_o rises when fewer than two queue entries are free, so a stalled
// receiver stops input after the queue fills; nothing is dropped.
// The 64-bit element product reuses one 32x32 multiplier for its partial
// products after each dimension; dimensions are at least eight bytes apart.
// Reset loads the register defaults, empties the queue and puts the parser
// at the magic word of a new file.
module gguf_tensor_info_parser_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  gtip_pkg::in_beat_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output gtip_pkg::out_beat_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [gtip_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gtip_pkg::CfgDataW-1:0]      cfg_data_i
);

  // Parser phases
  localparam logic [4:0] PH_MAGIC   = 5'd0;
  localparam logic [4:0] PH_VERSION = 5'd1;
  localparam logic [4:0] PH_NTENS   = 5'd2;
  localparam logic [4:0] PH_NKV     = 5'd3;
  localparam logic [4:0] PH_KEYLEN  = 5'd4;
  localparam logic [4:0] PH_KEY     = 5'd5;
  localparam logic [4:0] PH_VTYPE   = 5'd6;
  localparam logic [4:0] PH_SKIP    = 5'd7;
  localparam logic [4:0] PH_STRLEN  = 5'd8;
  localparam logic [4:0] PH_ATYPE   = 5'd9;
  localparam logic [4:0] PH_ALEN    = 5'd10;
  localparam logic [4:0] PH_ASLEN   = 5'd11;
  localparam logic [4:0] PH_ASTR    = 5'd12;
  localparam logic [4:0] PH_NAMELEN = 5'd13;
  localparam logic [4:0] PH_NAME    = 5'd14;
  localparam logic [4:0] PH_NDIMS   = 5'd15;
  localparam logic [4:0] PH_DIM     = 5'd16;
  localparam logic [4:0] PH_TYPE    = 5'd17;
  localparam logic [4:0] PH_OFFSET  = 5'd18;
  localparam logic [4:0] PH_DONE    = 5'd19;
  localparam logic [4:0] PH_ERROR   = 5'd20;

  function automatic logic [3:0] field_len(input logic [4:0] p);
    logic [3:0] l;
    unique case (p)
      PH_MAGIC, PH_VERSION, PH_VTYPE, PH_ATYPE, PH_NDIMS, PH_TYPE: l = 4'd4;
      PH_NTENS, PH_NKV, PH_KEYLEN, PH_STRLEN, PH_ALEN, PH_ASLEN,
      PH_NAMELEN, PH_DIM, PH_OFFSET:                               l = 4'd8;
      default:                                                     l = 4'd0;
    endcase
    return l;
  endfunction

  // Configuration registers
  logic [39:0] fs_q;
  logic [15:0] max_kv_q, max_tens_q, max_key_q;
  logic [23:0] max_str_q;
  logic [7:0]  name_lim_q;
  logic [12:0] rec_cap_q;

  // Parser state
  logic [4:0]  ph_q, ph_d;
  logic [39:0] pos_q, pos_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  seen_q, seen_d;
  logic [39:0] skip_q, skip_d;
  logic [15:0] pairs_q, pairs_d;
  logic [12:0] recs_q, recs_d;
  logic [11:0] rn_q, rn_d;
  logic [31:0] aitype_q, aitype_d;
  logic [63:0] aitems_q, aitems_d;
  logic [31:0] ndims_q, ndims_d;
  logic [2:0]  slot_q, slot_d;
  logic [63:0] dimv_q [4];
  logic [63:0] dimv_d [4];
  logic [63:0] prod_q, prod_d;
  logic [31:0] rtype_q, rtype_d;
  logic [7:0]  nleft_q, nleft_d;
  logic        over_q, over_d;

  // Step outcome
  logic                accept, restart;
  logic                prim_v, term_v, mul_start;
  gtip_pkg::out_beat_t prim, term;
  logic [63:0]         mul_b_d;

  // Multiplier sequencer
  logic [1:0]  mul_cnt_q;
  logic [63:0] mul_a_q, mul_b_q, mul_acc_q;
  logic [31:0] mul_opa, mul_opb;
  logic [63:0] mul_p, mul_hi;

  // Result queue
  gtip_pkg::out_beat_t q_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign accept  = in_valid_i && !in_stall_o;
  assign restart = accept && in_data_i.first_byte;

  // Parse one byte
  always_comb begin : p_step
    logic [63:0] v;
    logic [39:0] bl;
    logic [3:0]  len;
    logic [1:0]  sh;
    logic [39:0] nsk;
    logic [63:0] cap;
    logic [2:0]  used;
    logic        fail, finish;
    logic [3:0]  code;
    logic        go_idone, go_item, go_pdone, go_kv, go_rec;

    v = '0; bl = '0; len = '0; sh = '0; nsk = '0; cap = '0; used = '0;
    fail = 1'b0; finish = 1'b0; code = '0;
    go_idone = 1'b0; go_item = 1'b0; go_pdone = 1'b0; go_kv = 1'b0; go_rec = 1'b0;
    prim_v = 1'b0; term_v = 1'b0; prim = '0; term = '0;
    mul_start = 1'b0; mul_b_d = '0;

    ph_d = ph_q; pos_d = pos_q; acc_d = acc_q; seen_d = seen_q; skip_d = skip_q;
    pairs_d = pairs_q; recs_d = recs_q; rn_d = rn_q; aitype_d = aitype_q;
    aitems_d = aitems_q; ndims_d = ndims_q; slot_d = slot_q; prod_d = prod_q;
    rtype_d = rtype_q; nleft_d = nleft_q; over_d = over_q;
    for (int i = 0; i < 4; i++) dimv_d[i] = dimv_q[i];

    // Restart on the first byte of a file
    if (restart) begin
      ph_d = PH_MAGIC; pos_d = '0; acc_d = '0; seen_d = '0; skip_d = '0;
      pairs_d = '0; recs_d = '0; rn_d = '0; aitype_d = '0; aitems_d = '0;
      ndims_d = '0; slot_d = '0; prod_d = 64'd1; rtype_d = '0; nleft_d = '0;
      over_d = 1'b0;
      for (int i = 0; i < 4; i++) dimv_d[i] = '0;
    end

    if (accept && ph_d != PH_DONE && ph_d != PH_ERROR) begin
      if (ph_d == PH_MAGIC && pos_d == '0 && fs_q < gtip_pkg::HEADER_BYTES) begin
        fail = 1'b1; code = gtip_pkg::ERR_SHORT;
      end else if (pos_d >= fs_q) begin
        fail = 1'b1; code = gtip_pkg::ERR_TRUNC;
      end else begin
        pos_d = pos_d + 40'd1;
        bl    = (fs_q > pos_d) ? fs_q - pos_d : '0;
        len   = field_len(ph_d);
        if (len != '0) begin
          // Accumulate a little-endian field
          v      = acc_d | ({56'd0, in_data_i.file_byte} << {seen_d[2:0], 3'b000});
          acc_d  = v;
          seen_d = seen_d + 4'd1;
          if (seen_d >= len) begin
            acc_d  = '0;
            seen_d = '0;
            unique case (ph_d)
              PH_MAGIC: begin
                if (v[31:0] != gtip_pkg::MAGIC_WORD) begin
                  fail = 1'b1; code = gtip_pkg::ERR_MAGIC;
                end else ph_d = PH_VERSION;
              end
              PH_VERSION: ph_d = PH_NTENS;
              PH_NTENS: begin
                over_d = v > {48'd0, max_tens_q};
                cap    = (rec_cap_q > gtip_pkg::MAX_RECORDS) ?
                         {51'd0, gtip_pkg::MAX_RECORDS} : {51'd0, rec_cap_q};
                recs_d = (v < cap) ? v[12:0] : cap[12:0];
                ph_d   = PH_NKV;
              end
              PH_NKV: begin
                if (v > {48'd0, max_kv_q} || over_d) begin
                  fail = 1'b1; code = gtip_pkg::ERR_COUNTS;
                end else begin
                  pairs_d = v[15:0];
                  go_kv   = 1'b1;
                end
              end
              PH_KEYLEN: begin
                if (v > {48'd0, max_key_q} || v >= {24'd0, bl}) begin
                  fail = 1'b1; code = gtip_pkg::ERR_KEY;
                end else if (v == '0) begin
                  if (bl <= 40'd4) begin
                    fail = 1'b1; code = gtip_pkg::ERR_VALUE;
                  end else ph_d = PH_VTYPE;
                end else begin
                  skip_d = v[39:0];
                  ph_d   = PH_KEY;
                end
              end
              PH_VTYPE: begin
                if (v[31:0] == gtip_pkg::VT_STRING) ph_d = PH_STRLEN;
                else if (v[31:0] == gtip_pkg::VT_ARRAY) ph_d = PH_ATYPE;
                else begin
                  sh = gtip_pkg::scalar_shift(v[31:0]);
                  if ((40'd1 << sh) > bl) begin
                    fail = 1'b1; code = gtip_pkg::ERR_VALUE;
                  end else begin
                    skip_d = 40'd1 << sh;
                    ph_d   = PH_SKIP;
                  end
                end
              end
              PH_STRLEN: begin
                if (v > {40'd0, max_str_q} || v >= {24'd0, bl}) begin
                  fail = 1'b1; code = gtip_pkg::ERR_STRING;
                end else if (v == '0) go_pdone = 1'b1;
                else begin
                  skip_d = v[39:0];
                  ph_d   = PH_SKIP;
                end
              end
              PH_ATYPE: begin
                aitype_d = v[31:0];
                ph_d     = PH_ALEN;
              end
              PH_ALEN: begin
                aitems_d = v;
                if (aitype_d == gtip_pkg::VT_STRING) go_item = 1'b1;
                else begin
                  sh = gtip_pkg::scalar_shift(aitype_d);
                  if (v > ({24'd0, bl} >> sh)) begin
                    fail = 1'b1; code = gtip_pkg::ERR_ARRAY;
                  end else begin
                    nsk = v[39:0] << sh;
                    if (nsk == '0) go_pdone = 1'b1;
                    else begin
                      skip_d = nsk;
                      ph_d   = PH_SKIP;
                    end
                  end
                end
              end
              PH_ASLEN: begin
                if (v > {40'd0, max_str_q} || v > {24'd0, bl}) begin
                  fail = 1'b1; code = gtip_pkg::ERR_ARRAY;
                end else if (v == '0) go_idone = 1'b1;
                else begin
                  skip_d = v[39:0];
                  ph_d   = PH_ASTR;
                end
              end
              PH_NAMELEN: begin
                if (v >= {56'd0, name_lim_q} || v >= {24'd0, bl}) begin
                  fail = 1'b1; code = gtip_pkg::ERR_NAME;
                end else begin
                  nleft_d = v[7:0];
                  ph_d    = (v == '0) ? PH_NDIMS : PH_NAME;
                end
              end
              PH_NDIMS: begin
                ndims_d = v[31:0];
                slot_d  = '0;
                ph_d    = (v == '0) ? PH_TYPE : PH_DIM;
              end
              PH_DIM: begin
                dimv_d[slot_d[1:0]] = v;
                mul_start = 1'b1;
                mul_b_d   = v;
                slot_d    = slot_d + 3'd1;
                used      = (ndims_d < 32'd4) ? ndims_d[2:0] : 3'd4;
                ph_d      = (slot_d < used) ? PH_DIM : PH_TYPE;
              end
              PH_TYPE: begin
                rtype_d = v[31:0];
                ph_d    = PH_OFFSET;
              end
              PH_OFFSET: begin
                prim_v            = 1'b1;
                prim.kind         = gtip_pkg::KIND_REC;
                prim.tensor_index = rn_d;
                prim.dim_count    = ndims_d;
                prim.dim0         = dimv_d[0];
                prim.dim1         = dimv_d[1];
                prim.dim2         = dimv_d[2];
                prim.dim3         = dimv_d[3];
                prim.elem_type    = rtype_d;
                prim.data_offset  = v;
                prim.byte_size    = gtip_pkg::tensor_bytes(prod_d, rtype_d);
                rn_d   = rn_d + 12'd1;
                recs_d = recs_d - 13'd1;
                go_rec = 1'b1;
              end
              default: ;
            endcase
          end
        end else begin
          // Byte-wise phases: name bytes and skipped spans
          unique case (ph_d)
            PH_NAME: begin
              prim_v            = 1'b1;
              prim.kind         = gtip_pkg::KIND_NAME;
              prim.tensor_index = rn_d;
              prim.name_byte    = in_data_i.file_byte;
              nleft_d = nleft_d - 8'd1;
              if (nleft_d == '0) ph_d = PH_NDIMS;
            end
            PH_KEY, PH_SKIP, PH_ASTR: begin
              skip_d = skip_d - 40'd1;
              if (skip_d == '0) begin
                if (ph_d == PH_KEY) begin
                  if (bl <= 40'd4) begin
                    fail = 1'b1; code = gtip_pkg::ERR_VALUE;
                  end else ph_d = PH_VTYPE;
                end else if (ph_d == PH_SKIP) go_pdone = 1'b1;
                else go_idone = 1'b1;
              end
            end
            default: ;
          endcase
        end

        // Resolve boundaries in order: item, pair, key/value, record
        if (go_idone) begin
          aitems_d = aitems_d - 64'd1;
          go_item  = 1'b1;
        end
        if (go_item) begin
          if (aitems_d == '0) go_pdone = 1'b1;
          else if (pos_d >= fs_q) finish = 1'b1;
          else if (bl < 40'd8) begin
            fail = 1'b1; code = gtip_pkg::ERR_ARRAY;
          end else ph_d = PH_ASLEN;
        end
        if (go_pdone) begin
          pairs_d = pairs_d - 16'd1;
          go_kv   = 1'b1;
        end
        if (go_kv) begin
          if (pos_d >= fs_q) finish = 1'b1;
          else if (pairs_d != '0) ph_d = PH_KEYLEN;
          else go_rec = 1'b1;
        end
        if (go_rec) begin
          if (recs_d == '0 || pos_d >= fs_q) finish = 1'b1;
          else begin
            for (int i = 0; i < 4; i++) dimv_d[i] = '0;
            prod_d  = 64'd1;
            ndims_d = '0;
            slot_d  = '0;
            rtype_d = '0;
            ph_d    = PH_NAMELEN;
          end
        end

        // Reaching the end inside a field
        if (!fail && !finish && pos_d >= fs_q) begin
          fail = 1'b1; code = gtip_pkg::ERR_TRUNC;
        end
      end
    end

    if (fail) begin
      ph_d = PH_ERROR; acc_d = '0; seen_d = '0;
      term_v            = 1'b1;
      term.kind         = gtip_pkg::KIND_ERR;
      term.tensor_index = rn_d;
      term.error_code   = code;
    end else if (finish) begin
      ph_d = PH_DONE; acc_d = '0; seen_d = '0;
      term_v            = 1'b1;
      term.kind         = gtip_pkg::KIND_DONE;
      term.tensor_index = rn_d;
      term.data_offset  = {23'd0, ({1'b0, pos_d} + 41'd255) & ~41'd255};
    end
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q       <= '0;
      max_kv_q   <= gtip_pkg::RST_MAX_KV;
      max_tens_q <= gtip_pkg::RST_MAX_TENS;
      max_key_q  <= gtip_pkg::RST_MAX_KEY;
      max_str_q  <= gtip_pkg::RST_MAX_STR;
      name_lim_q <= gtip_pkg::RST_NAME_LIM;
      rec_cap_q  <= gtip_pkg::RST_REC_CAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gtip_pkg::CFG_FILE_SIZE:   fs_q       <= cfg_data_i;
        gtip_pkg::CFG_MAX_KV:      max_kv_q   <= cfg_data_i[15:0];
        gtip_pkg::CFG_MAX_TENSORS: max_tens_q <= cfg_data_i[15:0];
        gtip_pkg::CFG_MAX_KEY:     max_key_q  <= cfg_data_i[15:0];
        gtip_pkg::CFG_MAX_STRING:  max_str_q  <= cfg_data_i[23:0];
        gtip_pkg::CFG_NAME_LIMIT:  name_lim_q <= cfg_data_i[7:0];
        gtip_pkg::CFG_RECORD_CAP:  rec_cap_q  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_MAGIC; pos_q <= '0; acc_q <= '0; seen_q <= '0; skip_q <= '0;
      pairs_q <= '0; recs_q <= '0; rn_q <= '0; aitype_q <= '0; aitems_q <= '0;
      ndims_q <= '0; slot_q <= '0; prod_q <= 64'd1; rtype_q <= '0;
      nleft_q <= '0; over_q <= 1'b0;
      for (int i = 0; i < 4; i++) dimv_q[i] <= '0;
    end else begin
      ph_q <= ph_d; pos_q <= pos_d; acc_q <= acc_d; seen_q <= seen_d;
      skip_q <= skip_d; pairs_q <= pairs_d; recs_q <= recs_d; rn_q <= rn_d;
      aitype_q <= aitype_d; aitems_q <= aitems_d; ndims_q <= ndims_d;
      slot_q <= slot_d; rtype_q <= rtype_d; nleft_q <= nleft_d; over_q <= over_d;
      for (int i = 0; i < 4; i++) dimv_q[i] <= dimv_d[i];
      // Product: multiplier result when done, unless a restart; else prod_d
      if (mul_cnt_q == 2'd3 && !restart) prod_q <= mul_acc_q + mul_hi;
      else prod_q <= prod_d;
    end
  end

  // 64x64 low product as three 32x32 partial products
  always_comb begin
    unique case (mul_cnt_q)
      2'd2:    begin mul_opa = mul_a_q[31:0];  mul_opb = mul_b_q[63:32]; end
      2'd3:    begin mul_opa = mul_a_q[63:32]; mul_opb = mul_b_q[31:0];  end
      default: begin mul_opa = mul_a_q[31:0];  mul_opb = mul_b_q[31:0];  end
    endcase
  end
  assign mul_p  = {32'd0, mul_opa} * {32'd0, mul_opb};
  assign mul_hi = {mul_p[31:0], 32'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_cnt_q <= '0;
    end else if (restart) begin
      mul_cnt_q <= '0;
    end else if (mul_start) begin
      mul_cnt_q <= 2'd1;
    end else if (mul_cnt_q != '0) begin
      mul_cnt_q <= mul_cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_a_q <= prod_d;
      mul_b_q <= mul_b_d;
    end
    if (mul_cnt_q == 2'd1) mul_acc_q <= mul_p;
    else if (mul_cnt_q == 2'd2) mul_acc_q <= mul_acc_q + mul_hi;
  end

  // Result queue: push up to two beats, pop one
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = q_q[rd_q];
  assign in_stall_o  = cnt_q > 3'd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + {1'b0, prim_v} + {1'b0, term_v};
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + {2'd0, prim_v} + {2'd0, term_v} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (prim_v) q_q[wr_q] <= prim;
    if (term_v) q_q[wr_q + {1'b0, prim_v}] <= term;
  end

endmodule

[tb/sv/gtip_checker.sv]
`timescale 1ns / 100ps

module gtip_checker
  import gtip_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_beat_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_beat_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef enum logic [4:0] {
    P_MAGIC, P_VERSION, P_NTENS, P_NKV, P_KEYLEN, P_KEY, P_VTYPE, P_SKIP,
    P_STRLEN, P_ATYPE, P_ALEN, P_ASLEN, P_ASTR, P_NAMELEN, P_NAME, P_NDIMS,
    P_DIM, P_TYPE, P_OFFSET, P_DONE, P_ERROR
  } parse_ph_e;

  // Register copies
  logic [39:0] cf_file_size;
  logic [15:0] cf_max_kv, cf_max_tens, cf_max_key;
  logic [23:0] cf_max_str;
  logic [7:0]  cf_name_lim;
  logic [12:0] cf_rec_cap;

  // Parser state
  parse_ph_e   ph;
  logic [39:0] pos;
  logic [63:0] acc, skip_left, arr_left, prod;
  int unsigned nseen, dslot;
  logic [15:0] pairs_left, recs_left;
  logic [11:0] rec_idx;
  logic [31:0] arr_kind, ndims, rtype;
  logic [63:0] dims [4];
  logic [7:0]  name_left;
  logic        tens_over;

  out_beat_t   parsed_q [$];
  int          nerr;

  function automatic logic [63:0] bytes_left();
    return (cf_file_size > pos) ? 64'(cf_file_size - pos) : 64'd0;
  endfunction

  function automatic logic [63:0] item_size(input logic [31:0] t);
    case (t)
      32'd0, 32'd1, 32'd7: return 64'd1;
      32'd2, 32'd3:        return 64'd2;
      32'd4, 32'd5, 32'd6: return 64'd4;
      default:             return 64'd8;
    endcase
  endfunction

  function automatic int unsigned field_bytes(input parse_ph_e p);
    case (p)
      P_MAGIC, P_VERSION, P_VTYPE, P_ATYPE, P_NDIMS, P_TYPE: return 4;
      P_NTENS, P_NKV, P_KEYLEN, P_STRLEN, P_ALEN, P_ASLEN, P_NAMELEN,
      P_DIM, P_OFFSET: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [63:0] size_bytes(input logic [63:0] n, input logic [31:0] t);
    case (t)
      32'd1:   return n * 64'd2;
      32'd2:   return (n / 64'd32) * 64'd18;
      32'd8:   return (n / 64'd32) * 64'd34;
      32'd12:  return (n / 64'd256) * 64'd144;
      32'd13:  return (n / 64'd256) * 64'd176;
      default: return n * 64'd4;
    endcase
  endfunction

  function automatic out_beat_t blank(input logic [1:0] k);
    out_beat_t b;
    b = '0;
    b.kind = k;
    b.tensor_index = rec_idx;
    return b;
  endfunction

  task automatic go(input parse_ph_e p);
    ph = p;
    acc = '0;
    nseen = 0;
  endtask

  task automatic raise(input logic [3:0] code);
    out_beat_t b;
    b = blank(KIND_ERR);
    b.error_code = code;
    parsed_q.push_back(b);
    go(P_ERROR);
  endtask

  task automatic end_ok();
    out_beat_t b;
    b = blank(KIND_DONE);
    b.data_offset = (64'(pos) + 64'd255) & ~64'd255;
    parsed_q.push_back(b);
    go(P_DONE);
  endtask

  task automatic restart();
    go(P_MAGIC);
    pos = '0; skip_left = '0; pairs_left = '0; recs_left = '0; rec_idx = '0;
    arr_kind = '0; arr_left = '0; ndims = '0; dslot = 0;
    for (int i = 0; i < 4; i++) dims[i] = '0;
    prod = 64'd1; rtype = '0; name_left = '0; tens_over = 1'b0;
  endtask

  task automatic rec_boundary();
    if (recs_left == 0 || pos >= cf_file_size) begin
      end_ok();
      return;
    end
    for (int i = 0; i < 4; i++) dims[i] = '0;
    prod = 64'd1; ndims = '0; dslot = 0; rtype = '0;
    go(P_NAMELEN);
  endtask

  task automatic kv_boundary();
    if (pos >= cf_file_size) end_ok();
    else if (pairs_left > 0) go(P_KEYLEN);
    else rec_boundary();
  endtask

  task automatic pair_done();
    pairs_left = pairs_left - 16'd1;
    kv_boundary();
  endtask

  task automatic skip_bytes(input logic [63:0] n);
    if (n == 0) begin
      pair_done();
      return;
    end
    skip_left = n;
    go(P_SKIP);
  endtask

  task automatic after_key();
    if (bytes_left() <= 4) raise(ERR_VALUE);
    else go(P_VTYPE);
  endtask

  task automatic next_str_item();
    if (arr_left == 0) pair_done();
    else if (pos >= cf_file_size) end_ok();
    else if (bytes_left() < 8) raise(ERR_ARRAY);
    else go(P_ASLEN);
  endtask

  task automatic str_item_done();
    arr_left = arr_left - 64'd1;
    next_str_item();
  endtask

  // Act on a completed little-endian field
  task automatic field_done(input logic [63:0] v);
    logic [63:0] s, cap;
    int unsigned used;
    out_beat_t b;
    case (ph)
      P_MAGIC: if (v != 64'(MAGIC_WORD)) raise(ERR_MAGIC); else go(P_VERSION);
      P_VERSION: go(P_NTENS);
      P_NTENS: begin
        tens_over = v > 64'(cf_max_tens);
        cap = (cf_rec_cap > 13'd4096) ? 64'd4096 : 64'(cf_rec_cap);
        recs_left = 16'((v < cap) ? v : cap);
        go(P_NKV);
      end
      P_NKV: begin
        if (v > 64'(cf_max_kv) || tens_over) raise(ERR_COUNTS);
        else begin
          pairs_left = 16'(v);
          kv_boundary();
        end
      end
      P_KEYLEN: begin
        if (v > 64'(cf_max_key) || v >= bytes_left()) raise(ERR_KEY);
        else if (v == 0) after_key();
        else begin
          skip_left = v;
          go(P_KEY);
        end
      end
      P_VTYPE: begin
        if (v == 64'(VT_STRING)) go(P_STRLEN);
        else if (v == 64'(VT_ARRAY)) go(P_ATYPE);
        else begin
          s = item_size(v[31:0]);
          if (s > bytes_left()) raise(ERR_VALUE); else skip_bytes(s);
        end
      end
      P_STRLEN: begin
        if (v > 64'(cf_max_str) || v >= bytes_left()) raise(ERR_STRING);
        else skip_bytes(v);
      end
      P_ATYPE: begin
        arr_kind = v[31:0];
        go(P_ALEN);
      end
      P_ALEN: begin
        arr_left = v;
        if (arr_kind == VT_STRING) next_str_item();
        else begin
          s = item_size(arr_kind);
          if (v > bytes_left() / s) raise(ERR_ARRAY); else skip_bytes(v * s);
        end
      end
      P_ASLEN: begin
        if (v > 64'(cf_max_str) || v > bytes_left()) raise(ERR_ARRAY);
        else if (v == 0) str_item_done();
        else begin
          skip_left = v;
          go(P_ASTR);
        end
      end
      P_NAMELEN: begin
        if (v >= 64'(cf_name_lim) || v >= bytes_left()) raise(ERR_NAME);
        else begin
          name_left = v[7:0];
          go((v == 0) ? P_NDIMS : P_NAME);
        end
      end
      P_NDIMS: begin
        ndims = v[31:0];
        dslot = 0;
        go((v == 0) ? P_TYPE : P_DIM);
      end
      P_DIM: begin
        dims[dslot & 3] = v;
        prod = prod * v;
        dslot++;
        used = (ndims < 4) ? ndims : 4;
        go((dslot < used) ? P_DIM : P_TYPE);
      end
      P_TYPE: begin
        rtype = v[31:0];
        go(P_OFFSET);
      end
      P_OFFSET: begin
        b = blank(KIND_REC);
        b.dim_count = ndims;
        b.dim0 = dims[0]; b.dim1 = dims[1]; b.dim2 = dims[2]; b.dim3 = dims[3];
        b.elem_type = rtype;
        b.data_offset = v;
        b.byte_size = size_bytes(prod, rtype);
        parsed_q.push_back(b);
        rec_idx = rec_idx + 12'd1;
        recs_left = recs_left - 16'd1;
        rec_boundary();
      end
      default: ;
    endcase
  endtask

  task automatic take_byte(input logic [7:0] d);
    int unsigned len;
    out_beat_t b;
    len = field_bytes(ph);
    if (len != 0) begin
      acc = acc | (64'(d) << (8 * (nseen & 7)));
      nseen++;
      if (nseen >= len) field_done(acc);
      return;
    end
    case (ph)
      P_NAME: begin
        b = blank(KIND_NAME);
        b.name_byte = d;
        parsed_q.push_back(b);
        name_left = name_left - 8'd1;
        if (name_left == 0) go(P_NDIMS);
      end
      P_KEY, P_SKIP, P_ASTR: begin
        skip_left = skip_left - 64'd1;
        if (skip_left == 0) begin
          if (ph == P_KEY) after_key();
          else if (ph == P_SKIP) pair_done();
          else str_item_done();
        end
      end
      default: ;
    endcase
  endtask

  task automatic parse_beat(input in_beat_t d);
    if (d.first_byte) restart();
    if (ph == P_DONE || ph == P_ERROR) return;
    if (ph == P_MAGIC && pos == 0 && cf_file_size < HEADER_BYTES) begin
      raise(ERR_SHORT);
      return;
    end
    if (pos >= cf_file_size) begin
      raise(ERR_TRUNC);
      return;
    end
    pos = pos + 40'd1;
    take_byte(d.file_byte);
    if (ph != P_DONE && ph != P_ERROR && pos >= cf_file_size) raise(ERR_TRUNC);
  endtask

  task automatic cmp(input string fld, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", fld, e, a);
      nerr++;
    end
  endtask

  // Predict on each input beat, compare each output beat
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t e, a;
    if (!rst_ni) begin
      cf_file_size = '0;
      cf_max_kv = RST_MAX_KV; cf_max_tens = RST_MAX_TENS; cf_max_key = RST_MAX_KEY;
      cf_max_str = RST_MAX_STR; cf_name_lim = RST_NAME_LIM; cf_rec_cap = RST_REC_CAP;
      restart();
      parsed_q.delete();
      nerr = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILE_SIZE:   cf_file_size = cfg_data_i[39:0];
          CFG_MAX_KV:      cf_max_kv = cfg_data_i[15:0];
          CFG_MAX_TENSORS: cf_max_tens = cfg_data_i[15:0];
          CFG_MAX_KEY:     cf_max_key = cfg_data_i[15:0];
          CFG_MAX_STRING:  cf_max_str = cfg_data_i[23:0];
          CFG_NAME_LIMIT:  cf_name_lim = cfg_data_i[7:0];
          CFG_RECORD_CAP:  cf_rec_cap = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        a = out_data_i;
        if (parsed_q.size() == 0) begin
          $error("unexpected result beat: kind %0d", a.kind);
          nerr++;
        end else begin
          e = parsed_q.pop_front();
          cmp("kind", e.kind, a.kind);
          cmp("tensor_index", e.tensor_index, a.tensor_index);
          cmp("name_byte", e.name_byte, a.name_byte);
          cmp("dim_count", e.dim_count, a.dim_count);
          cmp("dim0", e.dim0, a.dim0);
          cmp("dim1", e.dim1, a.dim1);
          cmp("dim2", e.dim2, a.dim2);
          cmp("dim3", e.dim3, a.dim3);
          cmp("elem_type", e.elem_type, a.elem_type);
          cmp("data_offset", e.data_offset, a.data_offset);
          cmp("byte_size", e.byte_size, a.byte_size);
          cmp("error_code", e.error_code, a.error_code);
        end
      end
      if (in_valid_i && !in_stall_i) parse_beat(in_data_i);
    end
    errors_o <= nerr;
    pending_o <= parsed_q.size();
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import gtip_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_beat_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_beat_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int                  errors;
  int                  pending;

  int                  tx_pct;
  int                  rx_pct;
  bit                  long_hold;
  logic [7:0]          file_q [$];
  int                  bytes_sent;

  gguf_tensor_info_parser_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  gtip_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Give up after a generous bound
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (1000) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_pct);
      end
    end
  end

  function automatic int elem_bytes(input logic [31:0] t);
    case (t)
      32'd0, 32'd1, 32'd7: return 1;
      32'd2, 32'd3:        return 2;
      32'd4, 32'd5, 32'd6: return 4;
      default:             return 8;
    endcase
  endfunction

  task automatic put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
  endtask

  // One key/value pair with random key and content
  task automatic gen_pair(input logic [31:0] vt, input logic [31:0] at);
    int kl, n, l;
    kl = $urandom_range(1, 10);
    put_le(kl, 8);
    put_rand(kl);
    put_le(vt, 4);
    if (vt == VT_STRING) begin
      n = $urandom_range(0, 8);
      put_le(n, 8);
      put_rand(n);
    end else if (vt == VT_ARRAY) begin
      put_le(at, 4);
      n = $urandom_range(0, 4);
      put_le(n, 8);
      if (at == VT_STRING) begin
        for (int i = 0; i < n; i++) begin
          l = $urandom_range(0, 5);
          put_le(l, 8);
          put_rand(l);
        end
      end else begin
        put_rand(n * elem_bytes(at));
      end
    end else begin
      put_rand(elem_bytes(vt));
    end
  endtask

  // One tensor record
  task automatic gen_tensor(input logic [31:0] et, input logic [31:0] nd);
    int nl;
    logic [63:0] d;
    nl = $urandom_range(1, 8);
    put_le(nl, 8);
    put_rand(nl);
    put_le(nd, 4);
    for (int i = 0; i < ((nd < 4) ? nd : 4); i++) begin
      if ($urandom_range(9) == 0) d = {$urandom, $urandom};
      else d = $urandom_range(1, 600);
      put_le(d, 8);
    end
    put_le(et, 4);
    put_le({$urandom, $urandom}, 8);
  endtask

  task automatic gen_header(input logic [63:0] ntens, input logic [63:0] nkv);
    put_le(MAGIC_WORD, 4);
    put_le(32'd3, 4);
    put_le(ntens, 8);
    put_le(nkv, 8);
  endtask

  // Header, every value kind and every tensor size rule
  task automatic build_full();
    logic [31:0] scal [12];
    logic [31:0] arrs [5];
    logic [31:0] ets [7];
    scal = '{0, 1, 2, 3, 4, 5, 6, 7, 10, 11, 12, 200};
    arrs = '{4, 8, 9, 0, 32'hFFFF_FFFF};
    ets = '{0, 1, 2, 8, 12, 13, 32'hDEAD_BEEF};
    file_q.delete();
    gen_header(7, 18);
    foreach (scal[i]) gen_pair(scal[i], 0);
    gen_pair(VT_STRING, 0);
    foreach (arrs[i]) gen_pair(VT_ARRAY, arrs[i]);
    foreach (ets[i]) gen_tensor(ets[i], i);
  endtask

  function automatic logic [31:0] rand_vt();
    case ($urandom_range(5))
      0: return VT_STRING;
      1: return VT_ARRAY;
      2: return $urandom;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic build_rand();
    int k, p;
    logic [63:0] nt, nk;
    logic [31:0] ets [6];
    ets = '{0, 1, 2, 8, 12, 13};
    file_q.delete();
    k = $urandom_range(0, 4);
    p = $urandom_range(0, 4);
    nt = ($urandom_range(19) == 0) ? {$urandom, $urandom} : 64'(k);
    nk = ($urandom_range(19) == 0) ? 64'($urandom_range(5, 70000)) : 64'(p);
    gen_header(nt, nk);
    for (int i = 0; i < p; i++) gen_pair(rand_vt(), rand_vt());
    for (int i = 0; i < k; i++)
      gen_tensor(($urandom_range(7) == 0) ? $urandom : ets[$urandom_range(5)],
                 $urandom_range(0, 5));
    if ($urandom_range(9) == 0) file_q[0] = 8'($urandom);
    if ($urandom_range(9) == 0) file_q[$urandom_range(file_q.size() - 1)] = 8'($urandom);
    put_rand($urandom_range(0, 4));
  endtask

  task automatic wr(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Wait for every expected beat, then let the block settle
  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [39:0] fsz, input logic [15:0] kv,
                         input logic [15:0] tens, input logic [15:0] key,
                         input logic [23:0] str, input logic [7:0] nlim,
                         input logic [12:0] cap);
    drain();
    wr(CFG_FILE_SIZE, fsz);
    wr(CFG_MAX_KV, 40'(kv));
    wr(CFG_MAX_TENSORS, 40'(tens));
    wr(CFG_MAX_KEY, 40'(key));
    wr(CFG_MAX_STRING, 40'(str));
    wr(CFG_NAME_LIMIT, 40'(nlim));
    wr(CFG_RECORD_CAP, 40'(cap));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_file(input bit mark);
    for (int i = 0; i < file_q.size(); i++) begin
      if ($urandom_range(99) < tx_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= '{file_byte: file_q[i], first_byte: (i == 0) ? mark : 1'b0};
      do @(posedge clk); while (in_stall);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Send the full file, or only its first keep bytes when keep is nonzero
  task automatic run_full(input logic [39:0] fsz, input logic [15:0] tens,
                          input logic [15:0] key, input logic [7:0] nlim,
                          input logic [12:0] cap, input bit bad_magic,
                          input int keep);
    build_full();
    if (bad_magic) file_q[3] = 8'h00;
    set_cfg((fsz == 0) ? 40'(file_q.size()) : fsz, 16'd1000, tens, key,
            RST_MAX_STR, nlim, cap);
    if (keep != 0) begin
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
    send_file(1'b1);
  endtask

  function automatic logic [15:0] pick16(input logic [15:0] lo, input logic [15:0] dflt);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return lo;
      default: return dflt;
    endcase
  endfunction

  initial begin
    int nfile, sz, m;
    logic [39:0] fsz;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    tx_pct = 0;
    rx_pct = 0;
    long_hold = 1'b0;
    bytes_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: nominal under a long receiver hold-off, then short file, bad magic,
    // counts, key, cut and huge size on the first bytes only
    long_hold = 1'b1;
    run_full(0, 16'd10000, 16'd1024, 8'd128, 13'd512, 1'b0, 0);
    run_full(40'd23, 16'd10000, 16'd1024, 8'd128, 13'd512, 1'b0, 30);
    run_full(40'd0, 16'd10000, 16'd1024, 8'd128, 13'd8191, 1'b1, 30);
    run_full(0, 16'd0, 16'd1024, 8'd128, 13'd512, 1'b0, 40);
    run_full(0, 16'd10000, 16'd0, 8'd128, 13'd512, 1'b0, 48);
    run_full(40'd60, 16'd10000, 16'd1024, 8'd128, 13'd512, 1'b0, 64);
    run_full(40'hFF_FFFF_FFFF, 16'd65535, 16'd65535, 8'd255, 13'd2, 1'b0, 120);

    // Random files under varying limits and idling
    nfile = 0;
    while (bytes_sent < 1850) begin
      m = nfile % 4;
      tx_pct = (m == 1) ? 46 : (m == 3) ? 20 : 0;
      rx_pct = (m == 2) ? 46 : (m == 3) ? 20 : 0;
      build_rand();
      sz = file_q.size();
      case ($urandom_range(19))
        0: fsz = $urandom_range(0, sz);
        1: fsz = sz + $urandom_range(1, 40);
        2: fsz = ($urandom_range(1)) ? 40'd0 : 40'd24;
        3: fsz = 40'hFF_FFFF_FFFF;
        default: fsz = sz;
      endcase
      set_cfg(fsz, pick16(16'd2, 16'd1000), pick16(16'd3, 16'd10000),
              pick16(16'd4, 16'd1024),
              ($urandom_range(9) == 0) ? 24'hFF_FFFF : 24'($urandom_range(3, 100000)),
              ($urandom_range(9) == 0) ? 8'd1 : 8'($urandom_range(2, 255)),
              ($urandom_range(4) == 0) ? 13'($urandom_range(1, 8191)) :
              ($urandom_range(4) == 0) ? 13'($urandom_range(1, 3)) : 13'd512);
      if (nfile % 17 == 4) long_hold = 1'b1;
      send_file($urandom_range(29) != 0);
      nfile++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gtip_pkg.sv
hw/rtl/gguf_tensor_info_parser_core.sv
tb/sv/gtip_checker.sv
tb/sv/tb.sv
